/* rtl/ovr_pkg.sv */
// ----------------------------------------------------------------------------
// ovr_pkg: shared definitions for the one-vs-rest linear classifier
// Field widths, request and register codes, control types, score saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ovr_pkg;

  // word field widths
  localparam int REQ_BITS         = 2;
  localparam int CLASS_SEL_BITS   = 4;
  localparam int FEATURE_SEL_BITS = 10;
  localparam int VALUE_BITS       = 16;
  localparam int FRAC_BITS        = VALUE_BITS - 4;
  localparam int SCORE_BITS       = 48;
  localparam int PROD_BITS        = 2 * VALUE_BITS;

  // configuration port
  localparam int CFG_INDEX_BITS   = 1;
  localparam int CFG_DATA_BITS    = 11;
  localparam int FEAT_COUNT_BITS  = 11;
  localparam int CLASS_COUNT_BITS = 5;
  localparam logic [FEAT_COUNT_BITS-1:0]  FEAT_COUNT_RST  = 11'd1024;
  localparam logic [CLASS_COUNT_BITS-1:0] CLASS_COUNT_RST = 5'd16;

  // default sizes
  localparam int MAX_FEATURES_DEF = 1024;
  localparam int MAX_CLASSES_DEF  = 16;

  localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
  localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

  typedef enum logic [REQ_BITS-1:0] {
    REQ_WEIGHT  = 2'd0,
    REQ_BIAS    = 2'd1,
    REQ_FEATURE = 2'd2
  } req_type_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_FEATURE_COUNT = 1'b0,
    CFG_CLASS_COUNT   = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  // per-class control that travels down the MAC pipeline
  typedef struct packed {
    logic valid;      // a class slot is in this stage
    logic add_prod;   // feature position holds a weight
    logic use_score;  // final pass and class is in use
    logic first;      // class zero
  } mac_ctrl_t;

  function automatic logic signed [SCORE_BITS-1:0] sat_add(
    input logic signed [SCORE_BITS-1:0] a,
    input logic signed [SCORE_BITS-1:0] b
  );
    logic signed [SCORE_BITS:0] sum;
    logic signed [SCORE_BITS-1:0] res;
    sum = {a[SCORE_BITS-1], a} + {b[SCORE_BITS-1], b};
    if (sum[SCORE_BITS] != sum[SCORE_BITS-1]) begin
      res = sum[SCORE_BITS] ? SCORE_MIN : SCORE_MAX;
    end else begin
      res = sum[SCORE_BITS-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/ovr_if.sv */
// ----------------------------------------------------------------------------
// ovr_if: channel interfaces of the classifier
// Input word, result word and configuration write channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ovr_item_if;
  import ovr_pkg::*;
  logic                               valid;
  logic                               ready;
  logic        [REQ_BITS-1:0]         req_type;
  logic        [CLASS_SEL_BITS-1:0]   class_sel;
  logic        [FEATURE_SEL_BITS-1:0] feature_sel;
  logic signed [VALUE_BITS-1:0]       value;
  logic                               last;

  modport source (output valid, req_type, class_sel, feature_sel, value, last,
                  input ready);
  modport sink   (input valid, req_type, class_sel, feature_sel, value, last,
                  output ready);
endinterface

interface ovr_result_if;
  import ovr_pkg::*;
  logic                          valid;
  logic                          ready;
  logic        [CLASS_SEL_BITS-1:0] best_class;
  logic signed [SCORE_BITS-1:0]  best_score;
  logic                          count_mismatch;

  modport source (output valid, best_class, best_score, count_mismatch,
                  input ready);
  modport sink   (input valid, best_class, best_score, count_mismatch,
                  output ready);
endinterface

interface ovr_cfg_if;
  import ovr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/ovr_ram.sv */
// ----------------------------------------------------------------------------
// ovr_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ovr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/ovr_mac.sv */
// ----------------------------------------------------------------------------
// ovr_mac: shared multiply-accumulate and arg-max pipeline
// Multiply, saturating accumulate with write-back, bias add, running max.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ovr_mac #(
  parameter int CLASS_BITS = 4
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  ovr_pkg::mac_ctrl_t                     ctrl_i,
  input  logic [CLASS_BITS-1:0]                  cls_i,
  input  logic signed [ovr_pkg::VALUE_BITS-1:0]  x_i,
  input  logic signed [ovr_pkg::VALUE_BITS-1:0]  weight_i,
  input  logic signed [ovr_pkg::SCORE_BITS-1:0]  acc_i,
  input  logic signed [ovr_pkg::VALUE_BITS-1:0]  bias_i,
  output logic                                   acc_we_o,
  output logic [CLASS_BITS-1:0]                  acc_waddr_o,
  output logic signed [ovr_pkg::SCORE_BITS-1:0]  acc_wdata_o,
  output logic                                   busy_o,
  output logic [CLASS_BITS-1:0]                  best_class_o,
  output logic signed [ovr_pkg::SCORE_BITS-1:0]  best_score_o
);
  import ovr_pkg::*;

  mac_ctrl_t ctrl1_q, ctrl2_q, ctrl3_q, ctrl4_q;
  logic [CLASS_BITS-1:0] cls1_q, cls2_q, cls3_q, cls4_q;

  logic signed [PROD_BITS-1:0]  prod_d, prod_q;
  logic signed [SCORE_BITS-1:0] acc2_q;
  logic signed [VALUE_BITS-1:0] bias2_q, bias3_q;
  logic signed [SCORE_BITS-1:0] addend, nacc_d, nacc_q;
  logic signed [SCORE_BITS-1:0] bias_scaled, score_d, score_q;
  logic signed [SCORE_BITS-1:0] best_score_q;
  logic [CLASS_BITS-1:0]        best_class_q;
  logic                         take_best;

  // stage 1: RAM data arrives, multiply
  assign prod_d = x_i * weight_i;

  // stage 2: saturating accumulate, write back
  assign addend      = ctrl2_q.add_prod ? SCORE_BITS'(prod_q) : '0;
  assign nacc_d      = sat_add(acc2_q, addend);
  assign acc_we_o    = ctrl2_q.valid;
  assign acc_waddr_o = cls2_q;
  assign acc_wdata_o = nacc_d;

  // stage 3: bias in score format
  assign bias_scaled = SCORE_BITS'(bias3_q) <<< FRAC_BITS;
  assign score_d     = sat_add(nacc_q, bias_scaled);

  // stage 4: running max, lowest index wins ties
  assign take_best = ctrl4_q.valid && ctrl4_q.use_score &&
                     (ctrl4_q.first || (score_q > best_score_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
      ctrl2_q <= '0;
      ctrl3_q <= '0;
      ctrl4_q <= '0;
    end else begin
      ctrl1_q <= ctrl_i;
      ctrl2_q <= ctrl1_q;
      ctrl3_q <= ctrl2_q;
      ctrl4_q <= ctrl3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cls1_q  <= cls_i;
    cls2_q  <= cls1_q;
    prod_q  <= prod_d;
    acc2_q  <= acc_i;
    bias2_q <= bias_i;
    cls3_q  <= cls2_q;
    nacc_q  <= nacc_d;
    bias3_q <= bias2_q;
    cls4_q  <= cls3_q;
    score_q <= score_d;
    if (take_best) begin
      best_class_q <= cls4_q;
      best_score_q <= score_q;
    end
  end

  assign busy_o       = ctrl1_q.valid | ctrl2_q.valid | ctrl3_q.valid | ctrl4_q.valid;
  assign best_class_o = best_class_q;
  assign best_score_o = best_score_q;

endmodule

`default_nettype wire

/* rtl/ovr_linear_classifier_core.sv */
// ----------------------------------------------------------------------------
// ovr_linear_classifier_core: one-vs-rest linear classifier, inference
// Weight and bias tables in RAM, class scores in a RAM, one shared MAC.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one word per handshake: a weight write, a bias write or a
//         feature value; weight and bias writes are taken back to back.
//   A feature word runs one pass of the shared MAC over every class slot:
//   the word is accepted, every class slot is issued in turn, the MAC
//   pipeline drains, and on the word marked last the result is loaded.
//   The drain keeps the score RAM read-modify-write loop in order.
//   out_o carries the winning class, its Q24.24 score and the count
//   mismatch flag, one word per vector, from an output register. A stalled
//   receiver does not hold the core back until the next result is ready;
//   that result then waits in the last pass state.
//   cfg_i writes feature_count (index 0) and class_count (index 1); it is
//   always ready and must only be used while the core is idle.
//   Reset (rst_ni low, async) clears the control state, the score valid
//   bits and the feature position and restores the register defaults.
//   The weight and bias RAMs are not cleared; write them before use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ovr_linear_classifier_core #(
  parameter int MAX_FEATURES = ovr_pkg::MAX_FEATURES_DEF,
  parameter int MAX_CLASSES  = ovr_pkg::MAX_CLASSES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ovr_item_if.sink      in_i,
  ovr_cfg_if.sink       cfg_i,
  ovr_result_if.source  out_o
);
  import ovr_pkg::*;

  // class index, feature index and position counter widths
  localparam int CB        = $clog2(MAX_CLASSES);
  localparam int FB        = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int PB        = $clog2(2 * MAX_FEATURES);
  localparam int WAW       = CB + FB;
  localparam int WDEPTH    = MAX_CLASSES * (2 ** FB);
  localparam int CSW       = CB + CLASS_SEL_BITS;
  localparam int FSW       = FB + FEATURE_SEL_BITS;
  localparam int CMPW      = PB + FEAT_COUNT_BITS;
  localparam logic [PB-1:0] POS_LIMIT  = PB'(2 * MAX_FEATURES - 1);
  localparam logic [CB-1:0] CLASS_LAST = CB'(MAX_CLASSES - 1);

  // control state
  state_e state_q, state_d;
  logic [CB-1:0] c_q;
  logic in_ready, issue, emit_load, out_free, in_fire;

  // per-vector state
  logic [PB-1:0] pos_q, pos_next;
  logic [FB-1:0] fpos_q;
  logic signed [VALUE_BITS-1:0] x_q;
  logic last_q, posok_q, mism_q;

  // configuration registers
  logic [FEAT_COUNT_BITS-1:0]  fc_q;
  logic [CLASS_COUNT_BITS-1:0] cc_q;
  logic [8:0] used_w;

  // score valid bits: an entry not written since the last vector reads zero
  logic [MAX_CLASSES-1:0] acc_valid_q;
  logic accv_q;

  // decoded write addresses
  logic [CSW-1:0] csel_w;
  logic [FSW-1:0] fsel_w;
  logic cls_ok, feat_ok, w_we, b_we;
  req_type_e req;

  // RAM ports
  logic [VALUE_BITS-1:0] w_rdata, b_rdata;
  logic [SCORE_BITS-1:0] acc_rdata;
  logic signed [SCORE_BITS-1:0] acc_gated;

  // MAC pipeline
  mac_ctrl_t ctrl0;
  logic acc_we, mac_busy;
  logic [CB-1:0] acc_waddr;
  logic signed [SCORE_BITS-1:0] acc_wdata;
  logic [CB-1:0] best_class;
  logic signed [SCORE_BITS-1:0] best_score;
  logic [CB+CLASS_SEL_BITS-1:0] best_wide;

  // result register
  logic out_valid_q;
  logic [CLASS_SEL_BITS-1:0] out_class_q;
  logic signed [SCORE_BITS-1:0] out_score_q;
  logic out_mism_q;

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  assign in_fire = in_i.valid && in_ready;
  assign req     = req_type_e'(in_i.req_type);
  assign csel_w  = CSW'(in_i.class_sel);
  assign fsel_w  = FSW'(in_i.feature_sel);
  assign cls_ok  = 32'(in_i.class_sel) < MAX_CLASSES;
  assign feat_ok = 32'(in_i.feature_sel) < MAX_FEATURES;

  always_comb begin
    w_we = 1'b0;
    b_we = 1'b0;
    unique case (req)
      REQ_WEIGHT: w_we = in_fire && cls_ok && feat_ok;
      REQ_BIAS:   b_we = in_fire && cls_ok;
      REQ_FEATURE: ;
      default: ;  // unused request code is dropped
    endcase
  end

  // position counter saturates at 2*MAX_FEATURES-1
  assign pos_next = (pos_q < POS_LIMIT) ? pos_q + 1'b1 : POS_LIMIT;

  // classes taking part in the arg-max: zero means one, clamp to the table
  always_comb begin
    if (cc_q == '0) begin
      used_w = 9'd1;
    end else if (32'(cc_q) > MAX_CLASSES) begin
      used_w = 9'(MAX_CLASSES);
    end else begin
      used_w = 9'(cc_q);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire && req == REQ_FEATURE) state_d = ST_RUN;
      ST_RUN:   if (c_q == CLASS_LAST) state_d = ST_DRAIN;
      ST_DRAIN: if (!mac_busy) state_d = last_q ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    issue     = 1'b0;
    emit_load = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready  = 1'b1;
      ST_RUN:   issue     = 1'b1;
      ST_DRAIN: ;
      ST_EMIT:  emit_load = out_free;
      default: ;
    endcase
  end

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      c_q         <= '0;
      pos_q       <= '0;
      acc_valid_q <= '0;
      accv_q      <= 1'b0;
      fc_q        <= FEAT_COUNT_RST;
      cc_q        <= CLASS_COUNT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      accv_q  <= acc_valid_q[c_q];

      // class slot counter runs 0..MAX_CLASSES-1 once per feature
      if (issue) begin
        c_q <= (c_q == CLASS_LAST) ? '0 : c_q + 1'b1;
      end

      if (in_fire && req == REQ_FEATURE) begin
        pos_q <= pos_next;
      end else if (emit_load) begin
        pos_q <= '0;
      end

      // write-back marks a score valid; a finished vector drops them all
      if (emit_load) begin
        acc_valid_q <= '0;
      end else if (acc_we) begin
        acc_valid_q[acc_waddr] <= 1'b1;
      end

      if (cfg_i.valid) begin
        unique case (cfg_reg_e'(cfg_i.index))
          CFG_FEATURE_COUNT: fc_q <= cfg_i.data[FEAT_COUNT_BITS-1:0];
          CFG_CLASS_COUNT:   cc_q <= cfg_i.data[CLASS_COUNT_BITS-1:0];
          default: ;
        endcase
      end

      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cfg_i.ready = 1'b1;

  // per-vector payload
  always_ff @(posedge clk_i) begin
    if (in_fire && req == REQ_FEATURE) begin
      x_q     <= in_i.value;
      last_q  <= in_i.last;
      fpos_q  <= pos_q[FB-1:0];
      posok_q <= 32'(pos_q) < MAX_FEATURES;
      mism_q  <= CMPW'(pos_next) != CMPW'(fc_q);
    end
    if (emit_load) begin
      out_class_q <= best_wide[CLASS_SEL_BITS-1:0];
      out_score_q <= best_score;
      out_mism_q  <= mism_q;
    end
  end

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  ovr_ram #(.WIDTH(VALUE_BITS), .DEPTH(WDEPTH)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i ({csel_w[CB-1:0], fsel_w[FB-1:0]}),
    .wdata_i (in_i.value),
    .raddr_i ({c_q, fpos_q}),
    .rdata_o (w_rdata)
  );

  ovr_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_CLASSES)) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (csel_w[CB-1:0]),
    .wdata_i (in_i.value),
    .raddr_i (c_q),
    .rdata_o (b_rdata)
  );

  // each slot is read once per pass and written back from MAC stage 2;
  // the drain before the next pass keeps reads behind writes
  ovr_ram #(.WIDTH(SCORE_BITS), .DEPTH(MAX_CLASSES)) u_score_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (c_q),
    .rdata_o (acc_rdata)
  );

  assign acc_gated = accv_q ? acc_rdata : '0;

  // --------------------------------------------------------------------------
  // MAC pipeline
  // --------------------------------------------------------------------------
  always_comb begin
    ctrl0.valid     = issue;
    ctrl0.add_prod  = posok_q;
    ctrl0.use_score = last_q && (9'(c_q) < used_w);
    ctrl0.first     = (c_q == '0);
  end

  ovr_mac #(.CLASS_BITS(CB)) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl0),
    .cls_i        (c_q),
    .x_i          (x_q),
    .weight_i     (w_rdata),
    .acc_i        (acc_gated),
    .bias_i       (b_rdata),
    .acc_we_o     (acc_we),
    .acc_waddr_o  (acc_waddr),
    .acc_wdata_o  (acc_wdata),
    .busy_o       (mac_busy),
    .best_class_o (best_class),
    .best_score_o (best_score)
  );

  assign best_wide = (CB + CLASS_SEL_BITS)'(best_class);

  assign out_o.valid          = out_valid_q;
  assign out_o.best_class     = out_class_q;
  assign out_o.best_score     = out_score_q;
  assign out_o.count_mismatch = out_mism_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> !mac_busy)
    else $error("input ready while MAC pipeline busy");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (c_q == '0))
    else $error("class slot counter not at zero between passes");

  a_no_wb_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> !acc_we)
    else $error("score write-back while loading result");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_load |=> (out_valid_q && (pos_q == '0) && (acc_valid_q == '0)))
    else $error("result load did not present word and reset vector state");

endmodule

`default_nettype wire
